// ===== hw/rtl/mev_pkg.sv =====
// ---------------------------------------------------------------------------
// mev_pkg
// Shared types and constants for the microcode entry validator.
// ---------------------------------------------------------------------------
package mev_pkg;

    // Result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_INVALID     = 3'd1;
    localparam logic [2:0] ST_UNKNOWN_FMT = 3'd2;
    localparam logic [2:0] ST_BAD_CSUM    = 3'd3;
    localparam logic [2:0] ST_BAD_EXT_TBL = 3'd4;
    localparam logic [2:0] ST_BAD_EXT_SUM = 3'd5;
    localparam logic [2:0] ST_BAD_EXT_SIG = 3'd6;

    // Configuration register indexes
    localparam logic CFG_MAX_LEN = 1'b0;
    localparam logic CFG_STRICT  = 1'b1;

    // Entry layout constants
    localparam logic [31:0] HDR_BYTES    = 32'd48;
    localparam logic [31:0] EXTHDR_BYTES = 32'd20;
    localparam logic [31:0] DEF_DATA     = 32'd2000;
    localparam logic [31:0] DEF_TOTAL    = 32'd2048;
    localparam logic [31:0] HDR_VERSION  = 32'd1;
    localparam logic [31:0] RECIP3       = 32'hAAAAAAAB;

    // Date check constants
    localparam logic [31:0] BCD_ADJ      = 32'h06666666;
    localparam logic [31:0] BCD_CARRY    = 32'h11111110;
    localparam logic [31:0] BCD_LIMIT    = 32'hA0000000;
    localparam logic [15:0] MIN_YEAR     = 16'h1995;
    localparam logic [7:0]  MAX_DAY      = 8'h31;
    localparam logic [7:0]  MAX_MONTH    = 8'h12;

    // Classified input word, as queued between front and back
    typedef struct packed {
        logic        first;
        logic [31:0] word;
        logic        is_one;
        logic        nonzero;
        logic [35:0] sig_len;   // word * 12 + 20
    } mev_item_t;

endpackage

// ===== hw/rtl/mev_front.sv =====
// ---------------------------------------------------------------------------
// mev_front
// Input classifier: tags each incoming word with the cheap per-word facts
// that the checking engine needs.
// ---------------------------------------------------------------------------
module mev_front (
    input  logic              first,
    input  logic [31:0]       word,
    output mev_pkg::mev_item_t item
);
    import mev_pkg::*;

    // Per-word classification
    always_comb begin
        item.first   = first;
        item.word    = word;
        item.is_one  = (word == HDR_VERSION);
        item.nonzero = (word != 32'd0);
        item.sig_len = 36'({word, 3'b000}) + 36'({word, 2'b00}) + 36'(EXTHDR_BYTES);
    end

endmodule

// ===== hw/rtl/mev_fifo.sv =====
// ---------------------------------------------------------------------------
// mev_fifo
// Short queue of classified words between the front and the checking engine.
// ---------------------------------------------------------------------------
module mev_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  mev_pkg::mev_item_t wr_item,
    output logic              rd_valid,
    input  logic              rd_ready,
    output mev_pkg::mev_item_t rd_item
);
    import mev_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mev_item_t         mem [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              push, pop;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== hw/rtl/mev_back.sv =====
// ---------------------------------------------------------------------------
// mev_back
// Checking engine: walks the entry word by word, keeps the running sums and
// header fields, and loads at most one status into the output register per entry.
// ---------------------------------------------------------------------------
module mev_back #(
    parameter int MIN_BUFFER_BYTES = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [31:0]       cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  mev_pkg::mev_item_t in_item,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_status,
    output logic [31:0]       m_entry_bytes,
    output logic [28:0]       m_ext_sig_count
);
    import mev_pkg::*;

    // Configuration
    logic [31:0] max_len_reg;
    logic        strict_reg;

    // Entry state
    logic        done_reg, done_next;
    logic        hdr_done_reg, hdr_done_next;
    logic [29:0] idx_reg, idx_next;
    logic [31:0] main_sum_reg, main_sum_next;
    logic [31:0] ext_sum_reg, ext_sum_next;
    logic [31:0] hsig_sum_reg, hsig_sum_next;
    logic [31:0] grp_sum_reg, grp_sum_next;
    logic [1:0]  grp_phase_reg, grp_phase_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] data_reg, data_next;
    logic [31:0] date_reg, date_next;
    logic        rev_nz_reg, rev_nz_next;
    logic        pend_sig_reg, pend_sig_next;
    logic [29:0] main_last_reg, main_last_next;
    logic [29:0] e_reg, e_next;
    logic [29:0] e_last_reg, e_last_next;
    logic [31:0] ext_reg, ext_next;
    logic [28:0] q_reg;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_status_reg, out_status_next;
    logic [31:0] out_bytes_reg, out_bytes_next;
    logic [28:0] out_count_reg, out_count_next;

    // Working values
    logic        fire, emit;
    logic [2:0]  st;
    logic [29:0] c_idx;
    logic [31:0] c_ms, c_tot, c_dat, c_ext, w;
    logic        c_hdr;
    logic [31:0] x_ext;
    logic [29:0] xq;
    logic [61:0] prod;
    logic        shape_ok;
    logic [2:0]  misc_st;

    // Date and revision checks
    function automatic logic bcd_ok(input logic [31:0] d);
        logic [31:0] s;
        s = d + BCD_ADJ;
        return (d < BCD_LIMIT) && (((s ^ d) & BCD_CARRY) == 32'd0);
    endfunction

    always_comb begin
        misc_st = ST_OK;
        priority if (date_reg == 32'd0) begin
            misc_st = ST_INVALID;
        end else if (strict_reg && !rev_nz_reg) begin
            misc_st = ST_INVALID;
        end else if (strict_reg && (!bcd_ok(date_reg) || date_reg[15:0] < MIN_YEAR
                     || date_reg[23:16] == 8'd0 || date_reg[23:16] > MAX_DAY
                     || date_reg[31:24] == 8'd0 || date_reg[31:24] > MAX_MONTH)) begin
            misc_st = ST_INVALID;
        end
    end

    // Extended table shape: (ext - 20) / 12 via reciprocal multiply
    assign x_ext    = ext_reg - EXTHDR_BYTES;
    assign xq       = x_ext[31:2];
    assign prod     = 62'(xq) * 62'(RECIP3);
    assign shape_ok = (ext_reg >= EXTHDR_BYTES) && (x_ext[1:0] == 2'b00)
                      && ((31'({q_reg, 1'b0}) + 31'(q_reg)) == 31'(xq));

    always_ff @(posedge aclk) begin
        q_reg <= prod[61:33];
    end

    assign fire     = in_valid && in_ready;
    assign in_ready = !out_valid_reg || m_ready;
    assign w        = in_item.word;

    // Word processing
    always_comb begin
        done_next      = done_reg;
        hdr_done_next  = hdr_done_reg;
        idx_next       = idx_reg;
        main_sum_next  = main_sum_reg;
        ext_sum_next   = ext_sum_reg;
        hsig_sum_next  = hsig_sum_reg;
        grp_sum_next   = grp_sum_reg;
        grp_phase_next = grp_phase_reg;
        total_next     = total_reg;
        data_next      = data_reg;
        date_next      = date_reg;
        rev_nz_next    = rev_nz_reg;
        pend_sig_next  = pend_sig_reg;
        main_last_next = main_last_reg;
        e_next         = e_reg;
        e_last_next    = e_last_reg;
        ext_next       = ext_reg;
        emit           = 1'b0;
        st             = ST_OK;
        c_idx          = idx_reg;
        c_ms           = 32'd0;
        c_tot          = total_reg;
        c_dat          = data_reg;
        c_ext          = 32'd0;
        c_hdr          = hdr_done_reg;

        if (fire && (in_item.first || !done_reg)) begin
            if (in_item.first) begin
                c_idx          = '0;
                c_tot          = 32'd0;
                c_dat          = 32'd0;
                c_hdr          = 1'b0;
                main_sum_next  = 32'd0;
                ext_sum_next   = 32'd0;
                hsig_sum_next  = 32'd0;
                grp_sum_next   = 32'd0;
                grp_phase_next = 2'd0;
                date_next      = 32'd0;
                rev_nz_next    = 1'b0;
                pend_sig_next  = 1'b0;
            end
            done_next = 1'b0;
            idx_next  = c_idx + 1'b1;

            if (c_idx <= 30'd8) begin
                // Header words
                c_ms          = main_sum_next + w;
                main_sum_next = c_ms;
                unique case (c_idx[3:0])
                    4'd0: begin
                        if (max_len_reg < 32'(MIN_BUFFER_BYTES)) begin
                            emit = 1'b1;
                            st   = ST_INVALID;
                        end else if (!in_item.is_one) begin
                            emit = 1'b1;
                            st   = ST_UNKNOWN_FMT;
                        end
                    end
                    4'd1: rev_nz_next = in_item.nonzero;
                    4'd2: date_next = w;
                    4'd3, 4'd4, 4'd6: hsig_sum_next = hsig_sum_next + w;
                    4'd7: c_dat = w;
                    4'd8: begin
                        if (c_dat != 32'd0) begin
                            c_tot = w;
                        end else begin
                            c_tot = DEF_TOTAL;
                            c_dat = DEF_DATA;
                        end
                        if (c_dat > c_tot || c_dat < HDR_BYTES
                            || (33'(c_dat) + 33'(HDR_BYTES)) > 33'(c_tot)
                            || c_dat[1:0] != 2'b00 || c_tot[1:0] != 2'b00
                            || (strict_reg && c_tot[9:0] != 10'd0)
                            || c_tot > max_len_reg) begin
                            emit = 1'b1;
                            st   = ST_INVALID;
                        end else begin
                            c_hdr          = 1'b1;
                            c_ext          = c_tot - HDR_BYTES - c_dat;
                            ext_next       = c_ext;
                            main_last_next = 30'd11 + c_dat[31:2];
                            e_last_next    = c_ext[31:2] - 1'b1;
                        end
                    end
                    default: ;
                endcase
                total_next = c_tot;
                data_next  = c_dat;
            end else if (c_idx <= main_last_reg) begin
                // Remaining header words and data words
                c_ms          = main_sum_reg + w;
                main_sum_next = c_ms;
                if (c_idx == main_last_reg) begin
                    e_next = '0;
                    priority if (c_ms != 32'd0) begin
                        emit = 1'b1;
                        st   = ST_BAD_CSUM;
                    end else if (ext_reg == 32'd0) begin
                        emit = 1'b1;
                        st   = misc_st;
                    end else if (!shape_ok) begin
                        emit = 1'b1;
                        st   = ST_BAD_EXT_TBL;
                    end
                end
            end else begin
                // Extended table words
                ext_sum_next = ext_sum_reg + w;
                e_next       = e_reg + 1'b1;
                if (e_reg == '0 && in_item.sig_len != 36'(ext_reg)) begin
                    emit = 1'b1;
                    st   = ST_BAD_EXT_TBL;
                end else begin
                    if (e_reg >= 30'd5) begin
                        if (grp_phase_reg == 2'd2) begin
                            if (grp_sum_reg + w != hsig_sum_reg) begin
                                pend_sig_next = 1'b1;
                            end
                            grp_sum_next   = 32'd0;
                            grp_phase_next = 2'd0;
                        end else begin
                            grp_sum_next   = grp_sum_reg + w;
                            grp_phase_next = grp_phase_reg + 1'b1;
                        end
                    end
                    if (e_reg == e_last_reg) begin
                        emit = 1'b1;
                        priority if (ext_sum_next != 32'd0) begin
                            st = ST_BAD_EXT_SUM;
                        end else if (pend_sig_next) begin
                            st = ST_BAD_EXT_SIG;
                        end else begin
                            st = misc_st;
                        end
                    end
                end
            end
            hdr_done_next = c_hdr;
            if (emit) begin
                done_next = 1'b1;
            end
        end
    end

    // Output register
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_bytes_next  = out_bytes_reg;
        out_count_next  = out_count_reg;
        if (fire && emit) begin
            out_valid_next  = 1'b1;
            out_status_next = st;
            out_bytes_next  = c_tot;
            out_count_next  = (c_hdr && shape_ok && c_idx > 30'd8) ? q_reg : 29'd0;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg   <= 32'hFFFF_FFFF;
            strict_reg    <= 1'b0;
            done_reg      <= 1'b1;
            hdr_done_reg  <= 1'b0;
            idx_reg       <= '0;
            main_sum_reg  <= 32'd0;
            ext_sum_reg   <= 32'd0;
            hsig_sum_reg  <= 32'd0;
            grp_sum_reg   <= 32'd0;
            grp_phase_reg <= 2'd0;
            total_reg     <= 32'd0;
            data_reg      <= 32'd0;
            date_reg      <= 32'd0;
            rev_nz_reg    <= 1'b0;
            pend_sig_reg  <= 1'b0;
            main_last_reg <= '0;
            e_reg         <= '0;
            e_last_reg    <= '0;
            ext_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_MAX_LEN: max_len_reg <= cfg_wdata;
                    CFG_STRICT:  strict_reg  <= cfg_wdata[0];
                    default: ;
                endcase
            end
            done_reg      <= done_next;
            hdr_done_reg  <= hdr_done_next;
            idx_reg       <= idx_next;
            main_sum_reg  <= main_sum_next;
            ext_sum_reg   <= ext_sum_next;
            hsig_sum_reg  <= hsig_sum_next;
            grp_sum_reg   <= grp_sum_next;
            grp_phase_reg <= grp_phase_next;
            total_reg     <= total_next;
            data_reg      <= data_next;
            date_reg      <= date_next;
            rev_nz_reg    <= rev_nz_next;
            pend_sig_reg  <= pend_sig_next;
            main_last_reg <= main_last_next;
            e_reg         <= e_next;
            e_last_reg    <= e_last_next;
            ext_reg       <= ext_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_status_reg <= out_status_next;
        out_bytes_reg  <= out_bytes_next;
        out_count_reg  <= out_count_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_status_reg;
    assign m_entry_bytes   = out_bytes_reg;
    assign m_ext_sig_count = out_count_reg;

    // Checks
    a_emit_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && emit) |=> done_reg)
        else $error("entry still open after its status was issued");
    a_past_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (!done_reg && idx_reg > 30'd8) |-> hdr_done_reg)
        else $error("body word processed without a checked header");
    a_sig_err_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(pend_sig_reg) |-> hdr_done_reg)
        else $error("signature error flagged outside the extended table");
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status != 3'd7))
        else $error("undefined status code issued");

endmodule

// ===== hw/rtl/microcode_entry_validator.sv =====
// ---------------------------------------------------------------------------
// microcode_entry_validator
// Streaming header, size and checksum validator for one version-1
// microcode update entry, one 32-bit word per transaction.
// ---------------------------------------------------------------------------
// Words are taken at one per clock while the short FIFO has room and queued
// into it; the checking engine retires one word per clock whenever its output
// register is free, so the sustained rate is one word per cycle while the
// status side accepts results. Each status passes through the queue and the
// output register. At most one status is issued per entry, on the word where
// a failing check or overall success is decided; words after it are dropped
// until the next word flagged first. Configuration writes take effect on the
// next clock and are meant to happen only while the block is idle.
// No clearing pass.
module microcode_entry_validator #(
    parameter int MIN_BUFFER_BYTES = 1024,
    parameter int FIFO_DEPTH       = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_first,
    input  logic [31:0] s_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_entry_bytes,
    output logic [28:0] m_ext_sig_count
);
    import mev_pkg::*;

    mev_item_t front_item;
    mev_item_t q_item;
    logic      q_valid;
    logic      q_ready;

    // Classify incoming words
    mev_front u_front (
        .first (s_first),
        .word  (s_word),
        .item  (front_item)
    );

    // Decoupling queue
    mev_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_item  (front_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    // Checking engine
    mev_back #(
        .MIN_BUFFER_BYTES (MIN_BUFFER_BYTES)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (q_valid),
        .in_ready        (q_ready),
        .in_item         (q_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_entry_bytes   (m_entry_bytes),
        .m_ext_sig_count (m_ext_sig_count)
    );

endmodule

// ===== test/microcode_entry_validator_chk.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// microcode_entry_validator_chk
// Watches the word and status channels of the entry validator. It tracks the
// configuration writes, predicts the status of each entry word by word, and
// compares every status transaction against the oldest prediction.
// ---------------------------------------------------------------------------
module microcode_entry_validator_chk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_first,
    input  logic [31:0] s_word,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic [31:0] m_entry_bytes,
    input  logic [28:0] m_ext_sig_count,
    output int          mismatches,
    output int          statuses_owed,
    output int          statuses_seen,
    output int          words_seen
);
    import mev_pkg::*;

    localparam logic [31:0] MIN_BUF  = 32'd1024;
    localparam logic [31:0] IDX_MASK = 32'h3FFFFFFF;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] entry_bytes;
        logic [28:0] sig_count;
    } verdict_t;

    verdict_t owed_q[$];

    // configuration copy
    logic [31:0] max_len;
    logic        strict;

    // entry tracking state
    logic [31:0] widx, main_sum, ext_sum, hdr_sig_sum, grp_sum, grp_phase;
    logic [31:0] total_b, data_b, date_w, sig_cnt;
    logic [2:0]  held_err;
    logic        rev_nz, done;

    function automatic logic [2:0] date_rev_status();
        logic [7:0] day, mon;
        logic       bcd;
        day = date_w[23:16];
        mon = date_w[31:24];
        bcd = (date_w < BCD_LIMIT) && ((((date_w + BCD_ADJ) ^ date_w) & BCD_CARRY) == 0);
        if (date_w == 0) return ST_INVALID;
        if (strict && !rev_nz) return ST_INVALID;
        if (strict && (!bcd || date_w[15:0] < MIN_YEAR || day == 0 || day > MAX_DAY ||
                       mon == 0 || mon > MAX_MONTH))
            return ST_INVALID;
        return ST_OK;
    endfunction

    // Advance the entry state by one word; hit is set when a status is due.
    task automatic judge_word(input logic f, input logic [31:0] w,
                              output bit hit, output logic [2:0] st);
        logic [31:0] idx, main_last, e, e_last;
        logic [63:0] t, d, xb;
        hit = 0;
        st  = ST_OK;
        if (f) begin
            widx = 0; main_sum = 0; ext_sum = 0; hdr_sig_sum = 0; grp_sum = 0;
            grp_phase = 0; total_b = 0; data_b = 0; date_w = 0; rev_nz = 0;
            sig_cnt = 0; held_err = ST_OK; done = 0;
        end else if (done) begin
            return;
        end
        idx  = widx;
        widx = (idx + 1) & IDX_MASK;
        if (idx <= 8) begin
            main_sum += w;
            case (idx)
                0: begin
                    if (max_len < MIN_BUF) begin
                        hit = 1; st = ST_INVALID;
                    end else if (w != HDR_VERSION) begin
                        hit = 1; st = ST_UNKNOWN_FMT;
                    end
                end
                1: rev_nz = (w != 0);
                2: date_w = w;
                3, 4, 6: hdr_sig_sum += w;
                7: data_b = w;
                8: begin
                    if (data_b != 0) begin
                        total_b = w;
                    end else begin
                        total_b = DEF_TOTAL;
                        data_b  = DEF_DATA;
                    end
                    t = total_b;
                    d = data_b;
                    if (d > t || d < 48 || d + 48 > t || d[1:0] != 0 || t[1:0] != 0 ||
                        (strict && t[9:0] != 0) || t > max_len) begin
                        hit = 1; st = ST_INVALID;
                    end else begin
                        xb = t - 48 - d;
                        if (xb >= 20 && (xb - 20) % 12 == 0) sig_cnt = 32'((xb - 20) / 12);
                    end
                end
                default: ;
            endcase
        end else begin
            main_last = 11 + data_b / 4;
            xb = {32'd0, total_b} - 48 - {32'd0, data_b};
            if (idx <= main_last) begin
                main_sum += w;
                if (idx == main_last) begin
                    hit = 1;
                    if (main_sum != 0) st = ST_BAD_CSUM;
                    else if (xb == 0) st = date_rev_status();
                    else if (xb < 20 || (xb - 20) % 12 != 0) st = ST_BAD_EXT_TBL;
                    else hit = 0;
                end
            end else begin
                e      = idx - main_last - 1;
                e_last = xb[33:2] - 1;
                ext_sum += w;
                if (e == 0 && {32'd0, w} * 12 + 20 != xb) begin
                    hit = 1; st = ST_BAD_EXT_TBL;
                end else begin
                    if (e >= 5) begin
                        grp_sum += w;
                        if (grp_phase == 2) begin
                            if (grp_sum != hdr_sig_sum) held_err = ST_BAD_EXT_SIG;
                            grp_sum = 0;
                            grp_phase = 0;
                        end else begin
                            grp_phase++;
                        end
                    end
                    if (e == e_last) begin
                        hit = 1;
                        if (ext_sum != 0) st = ST_BAD_EXT_SUM;
                        else if (held_err != ST_OK) st = held_err;
                        else st = date_rev_status();
                    end
                end
            end
        end
        if (hit) done = 1;
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    assign statuses_owed = owed_q.size();

    always @(posedge aclk) begin
        bit         hit;
        logic [2:0] st;
        verdict_t   v;
        if (!aresetn) begin
            max_len = 32'hFFFFFFFF; strict = 0; done = 1; widx = 0;
            owed_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_MAX_LEN) max_len = cfg_wdata;
                else strict = cfg_wdata[0];
            end
            // word transaction
            if (s_valid && s_ready) begin
                words_seen++;
                judge_word(s_first, s_word, hit, st);
                if (hit) begin
                    v.status = st; v.entry_bytes = total_b; v.sig_count = sig_cnt[28:0];
                    owed_q.push_back(v);
                end
            end
            // status transaction
            if (m_valid && m_ready) begin
                statuses_seen++;
                if (owed_q.size() == 0) begin
                    report("unexpected status", 32'(m_status), 32'd0);
                end else begin
                    v = owed_q.pop_front();
                    if (m_status !== v.status)
                        report("status", 32'(m_status), 32'(v.status));
                    if (m_entry_bytes !== v.entry_bytes)
                        report("entry_bytes", m_entry_bytes, v.entry_bytes);
                    if (m_ext_sig_count !== v.sig_count)
                        report("ext_sig_count", 32'(m_ext_sig_count), 32'(v.sig_count));
                end
            end
        end
    end

    initial begin
        mismatches = 0; statuses_seen = 0; words_seen = 0;
    end

endmodule

// ===== test/microcode_entry_validator_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// microcode_entry_validator_tb
// Feeds built update entries (clean and corrupted in many ways) through the
// validator under several configurations, with random stalls on both sides;
// the checker instance predicts and compares each status.
// ---------------------------------------------------------------------------
module microcode_entry_validator_tb;
    import mev_pkg::*;

    localparam int LIMIT = 600000;

    // entry corruption kinds
    localparam int CLEAN       = 0;
    localparam int FLIP_WORD   = 1;
    localparam int BAD_VERSION = 2;
    localparam int CUT_SHORT   = 3;
    localparam int BAD_SIG     = 4;
    localparam int BAD_EXTCNT  = 5;
    localparam int ZERO_DATE   = 6;
    localparam int ZERO_REV    = 7;
    localparam int WILD_DATE   = 8;
    localparam int NUM_KINDS   = 9;

    logic        aclk, aresetn;
    logic        cfg_we, cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_valid, s_ready, s_first;
    logic [31:0] s_word;
    logic        m_valid, m_ready;
    logic [2:0]  m_status;
    logic [31:0] m_entry_bytes;
    logic [28:0] m_ext_sig_count;

    int  mismatches, owed, seen, words_seen;
    bit  calm, hold_req;
    int  words_sent;
    logic [31:0] ent[$];

    microcode_entry_validator dut (.*);

    microcode_entry_validator_chk chk (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata,
        .s_valid, .s_ready, .s_first, .s_word,
        .m_valid, .m_ready, .m_status, .m_entry_bytes, .m_ext_sig_count,
        .mismatches(mismatches), .statuses_owed(owed), .statuses_seen(seen),
        .words_seen(words_seen)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // run limit
    initial begin
        repeat (LIMIT) @(posedge aclk);
        $display("Simulation FAILED");
        $finish;
    end

    // status receiver with random stalls and one long hold-off on request
    initial begin
        int gap;
        m_ready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 0;
                repeat (400) @(negedge aclk);
                hold_req = 0;
            end
            gap = calm ? 0 : $urandom_range(0, 16);
            if (gap != 0) begin
                m_ready <= 0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    function automatic logic [31:0] to_bcd(input int v);
        logic [31:0] r;
        r = 0;
        for (int i = 0; i < 8; i++) begin
            r[i*4 +: 4] = 4'(v % 10);
            v = v / 10;
        end
        return r;
    endfunction

    // one word transaction; called and returns at a falling edge
    task automatic push_word(input logic f, input logic [31:0] w);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_valid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1;
        s_first <= f;
        s_word  <= w;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        words_sent++;
    endtask

    task automatic settle();
        s_valid <= 0;
        while (owed != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 0;
        @(negedge aclk);
    endtask

    // Build an entry in ent: dw data words (0 = default size), nsig
    // extended signatures (-1 = no table), size_adj added to the total unless dw is 0.
    task automatic build_entry(input int dw, input int nsig, input int size_adj, input int kind);
        logic [31:0] sum, total, hsig, dbytes;
        logic [31:0] mon_b, day_b, yr_b;
        int xbytes, n_data, base;
        n_data = (dw == 0) ? 500 : dw;
        dbytes = dw * 4;
        xbytes = (nsig < 0) ? 0 : 20 + 12 * nsig;
        total  = (dw == 0) ? DEF_TOTAL : 48 + dbytes + xbytes + size_adj;
        mon_b  = to_bcd($urandom_range(1, 12));
        day_b  = to_bcd($urandom_range(1, 31));
        yr_b   = to_bcd($urandom_range(1995, 2099));
        ent.delete();
        ent.push_back(HDR_VERSION);
        ent.push_back((kind == ZERO_REV) ? 32'd0 : ($urandom() | 32'd1));
        ent.push_back((kind == ZERO_DATE) ? 32'd0 :
                      (kind == WILD_DATE) ? $urandom() :
                      {mon_b[7:0], day_b[7:0], yr_b[15:0]});
        ent.push_back($urandom());
        ent.push_back(0);
        ent.push_back($urandom());
        ent.push_back($urandom());
        ent.push_back(dbytes);
        ent.push_back((dw == 0) ? $urandom() : total);
        for (int i = 0; i < 3 + n_data; i++) ent.push_back($urandom());
        // header checksum word zeroes the main sum
        sum = 0;
        foreach (ent[i]) sum += ent[i];
        ent[4] = -sum;
        hsig = ent[3] + ent[4] + ent[6];
        if (nsig >= 0) begin
            base = ent.size();
            ent.push_back(nsig);
            ent.push_back(0);
            repeat (3) ent.push_back($urandom());
            for (int i = 0; i < nsig; i++) begin
                ent.push_back($urandom());
                ent.push_back($urandom());
                ent.push_back(hsig - ent[ent.size()-1] - ent[ent.size()-2]);
            end
            if (kind == BAD_SIG && nsig > 0) ent[base + 5 + 3 * $urandom_range(0, nsig-1)] ^= 1;
            if (kind == BAD_EXTCNT) ent[base] += $urandom_range(1, 3);
            sum = 0;
            for (int i = base; i < ent.size(); i++) sum += ent[i];
            ent[base + 1] = -sum;
        end
        if (kind == BAD_VERSION) ent[0] = $urandom_range(0, 1) ? 32'd0 : $urandom();
        if (kind == FLIP_WORD) ent[$urandom_range(0, ent.size()-1)] ^= 32'd1 << $urandom_range(0, 31);
        if (kind == CUT_SHORT) ent = ent[0 : $urandom_range(0, ent.size()-2)];
    endtask

    task automatic send_entry();
        foreach (ent[i]) push_word(i == 0, ent[i]);
    endtask

    task automatic random_entry(input bit strict_fit);
        int dw, nsig, adj, kind;
        nsig = $urandom_range(0, 1) ? -1 : $urandom_range(0, 4);
        dw   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 11) : $urandom_range(12, 40);
        adj  = ($urandom_range(0, 7) == 0) ?
               4 * (int'($urandom_range(0, 6)) - 3) + int'($urandom_range(0, 1)) : 0;
        kind = ($urandom_range(0, 2) == 0) ? $urandom_range(1, NUM_KINDS-1) : CLEAN;
        if (strict_fit && $urandom_range(0, 1)) begin
            nsig = -1;
            dw   = 244;
        end
        if ($urandom_range(0, 60) == 0) dw = 0;
        build_entry(dw, nsig, adj, kind);
        send_entry();
        // trailing ignored words
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) push_word(0, $urandom());
    endtask

    initial begin
        logic [31:0] lens[6];
        bit          strict_of[6];
        cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
        s_valid = 0; s_first = 0; s_word = 0;
        calm = 0; hold_req = 0; words_sent = 0;
        aresetn = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // directed: words before any first, then clean entries and one each of six corruption kinds
        push_word(0, 32'hFFFFFFFF);
        push_word(0, 32'h0);
        build_entry(12, -1, 0, CLEAN);        send_entry();
        build_entry(16, 2, 0, CLEAN);         send_entry();
        build_entry(0, -1, 0, CLEAN);         send_entry();
        build_entry(12, -1, 0, BAD_VERSION);  send_entry();
        build_entry(12, 1, 0, FLIP_WORD);     send_entry();
        build_entry(12, 3, 0, BAD_SIG);       send_entry();
        build_entry(12, 2, 0, BAD_EXTCNT);    send_entry();
        build_entry(12, -1, 8, CLEAN);        send_entry();
        build_entry(12, -1, 0, ZERO_DATE);    send_entry();
        build_entry(12, -1, 0, CUT_SHORT);    send_entry();
        build_entry(11, -1, 0, CLEAN);        send_entry();
        settle();

        // strict mode with exact length limit
        write_reg(CFG_STRICT, 1);
        write_reg(CFG_MAX_LEN, 32'd1024);
        build_entry(244, -1, 0, CLEAN);       send_entry();
        build_entry(244, -1, 0, ZERO_REV);    send_entry();
        build_entry(244, -1, 0, WILD_DATE);   send_entry();
        build_entry(12, -1, 0, CLEAN);        send_entry();
        settle();

        // random phases over several settings
        lens      = '{32'hFFFFFFFF, 32'd1023, 32'hFFFFFFFF, 32'd0, 32'd4096, 32'd1024};
        strict_of = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        for (int ph = 0; ph < 12; ph++) begin
            int budget;
            write_reg(CFG_MAX_LEN, (ph == 6) ? $urandom_range(1024, 3000) : lens[ph % 6]);
            write_reg(CFG_STRICT, strict_of[ph % 6]);
            calm = (ph == 4 || ph == 9);
            if (ph == 2) hold_req = 1;
            budget = words_sent + ((lens[ph % 6] < 1024 && ph != 6) ? 5 : 40);
            while (words_sent < budget)
                random_entry(strict_of[ph % 6] && lens[ph % 6] >= 32'd1024);
            settle();
        end

        repeat (30) @(negedge aclk);
        $display("Run covered %0d word transactions and %0d status transactions,", words_seen,
                 seen);
        $display("with length limits at both extremes and strict mode on and off.");
        if (mismatches == 0 && owed == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mev_pkg.sv
hw/rtl/mev_front.sv
hw/rtl/mev_fifo.sv
hw/rtl/mev_back.sv
hw/rtl/microcode_entry_validator.sv
test/microcode_entry_validator_chk.sv
test/microcode_entry_validator_tb.sv
